FILE: hdl/bis_pkg.sv
// ---------------------------------------------------------------------------
// bis_pkg
// Shared types and constants of the bilinear image scaler: item structs,
// register indexes, controller states and the datapath command group.
// ---------------------------------------------------------------------------
package bis_pkg;

  localparam int COORD_W    = 12;
  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 3 * CHAN_W;
  localparam int SIZE_W     = 9;
  localparam int SCALE_W    = 17;
  localparam int POS_W      = COORD_W + SCALE_W;
  localparam int IPART_W    = POS_W - 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [SCALE_W-1:0] ONE_Q16 = 17'h10000;
  localparam logic [SIZE_W-1:0]  SIZE_RST = 9'd256;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE  = 2'd2;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic              func;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [CHAN_W-1:0]  red_in;
    logic [CHAN_W-1:0]  green_in;
    logic [CHAN_W-1:0]  blue_in;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP,
    S_RD0,
    S_RD1,
    S_RD2,
    S_RD3,
    S_ACC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       wr_en;
    logic       pos_load;
    logic       map_en;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       acc_clr;
    logic       acc_en;
    logic       out_load;
  } dp_cmd_t;

endpackage

FILE: hdl/bis_ram.sv
// ---------------------------------------------------------------------------
// bis_ram
// Generic single-port RAM with one write and registered read data.
// ---------------------------------------------------------------------------
module bis_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/bis_ctrl.sv
// ---------------------------------------------------------------------------
// bis_ctrl
// Controller: sequences one query through map, four reads and the blend,
// and owns the input stall and the result valid.
// ---------------------------------------------------------------------------
module bis_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_func,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output bis_pkg::dp_cmd_t cmd
);
  import bis_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_func == FUNC_QUERY) begin
            cmd.pos_load = 1'b1;
            state_nxt    = S_MAP;
          end else begin
            cmd.wr_en = 1'b1;
          end
        end
      end
      S_MAP: begin
        cmd.map_en  = 1'b1;
        cmd.acc_clr = 1'b1;
        state_nxt   = S_RD0;
      end
      S_RD0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = 2'd0;
        state_nxt  = S_RD1;
      end
      // the read stages after S_RD0 also fold in the pixel fetched in the state before
      S_RD1: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = 2'd1;
        cmd.acc_en = 1'b1;
        state_nxt  = S_RD2;
      end
      S_RD2: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = 2'd2;
        cmd.acc_en = 1'b1;
        state_nxt  = S_RD3;
      end
      S_RD3: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = 2'd3;
        cmd.acc_en = 1'b1;
        state_nxt  = S_ACC;
      end
      S_ACC: begin
        cmd.acc_en = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: hdl/bis_dp.sv
// ---------------------------------------------------------------------------
// bis_dp
// Datapath: configuration registers, coordinate mapping, frame store,
// weight generation, per-channel accumulation and the result register.
// ---------------------------------------------------------------------------
module bis_dp #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bis_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bis_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  bis_pkg::in_item_t                   in_data,
  input  bis_pkg::dp_cmd_t                    cmd,
  output bis_pkg::out_item_t                  out_data
);
  import bis_pkg::*;

  localparam int CB    = $clog2(MAX_WIDTH);
  localparam int RB    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = 2 * FRAC_BITS + 2;
  localparam int ACC_W = 2 * FRAC_BITS + 10;
  localparam logic [IPART_W-1:0] MAXW_I = IPART_W'(MAX_WIDTH);
  localparam logic [IPART_W-1:0] MAXH_I = IPART_W'(MAX_HEIGHT);
  localparam logic [AW-1:0]      MAXW_A = AW'(MAX_WIDTH);
  localparam logic [FRAC_BITS:0] ONE_F  = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  // configuration
  logic [SIZE_W-1:0]  src_width_r, src_height_r;
  logic [SCALE_W-1:0] inv_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= SIZE_RST;
      src_height_r <= SIZE_RST;
      inv_scale_r  <= ONE_Q16;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_WIDTH:  src_width_r  <= cfg_data[SIZE_W-1:0];
        REG_SRC_HEIGHT: src_height_r <= cfg_data[SIZE_W-1:0];
        REG_INV_SCALE:  inv_scale_r  <= cfg_data[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // coordinate times reciprocal scale
  logic [SCALE_W-1:0] scl;
  logic [POS_W-1:0]   pos_row, pos_col;
  logic [POS_W-1:0]   pos_row_r, pos_col_r;

  assign scl     = (inv_scale_r > ONE_Q16) ? ONE_Q16 : inv_scale_r;
  assign pos_row = in_data.row * scl;
  assign pos_col = in_data.col * scl;

  always_ff @(posedge clk) begin
    if (cmd.pos_load) begin
      pos_row_r <= pos_row;
      pos_col_r <= pos_col;
    end
  end

  // clamp the integer parts to the effective image size
  logic [IPART_W-1:0]   w_ext, h_ext, eff_w, eff_h, last_w, last_h;
  logic [IPART_W-1:0]   ip_r, ip_c;
  logic [RB-1:0]        r0, r1, last_r;
  logic [CB-1:0]        c0, c1, last_c;
  logic [RB-1:0]        r0_r, r1_r;
  logic [CB-1:0]        c0_r, c1_r;
  logic [FRAC_BITS-1:0] fr_r, fc_r;

  assign w_ext  = IPART_W'(src_width_r);
  assign h_ext  = IPART_W'(src_height_r);
  assign eff_w  = (w_ext == '0) ? IPART_W'(1) : ((w_ext > MAXW_I) ? MAXW_I : w_ext);
  assign eff_h  = (h_ext == '0) ? IPART_W'(1) : ((h_ext > MAXH_I) ? MAXH_I : h_ext);
  assign last_w = eff_w - IPART_W'(1);
  assign last_h = eff_h - IPART_W'(1);
  assign last_c = last_w[CB-1:0];
  assign last_r = last_h[RB-1:0];
  assign ip_r   = pos_row_r[POS_W-1:16];
  assign ip_c   = pos_col_r[POS_W-1:16];

  assign r0 = (ip_r >= last_h) ? last_r : ip_r[RB-1:0];
  assign c0 = (ip_c >= last_w) ? last_c : ip_c[CB-1:0];
  assign r1 = (r0 == last_r) ? r0 : r0 + RB'(1);
  assign c1 = (c0 == last_c) ? c0 : c0 + CB'(1);

  always_ff @(posedge clk) begin
    if (cmd.map_en) begin
      r0_r <= r0;
      r1_r <= r1;
      c0_r <= c0;
      c1_r <= c1;
      fr_r <= pos_row_r[15 -: FRAC_BITS];
      fc_r <= pos_col_r[15 -: FRAC_BITS];
    end
  end

  // frame store addressing
  logic                 wr_in_range, ram_we;
  logic [AW-1:0]        wr_addr, rd_addr, ram_addr;
  logic [RB-1:0]        rd_row;
  logic [CB-1:0]        rd_col;
  logic [PIX_W-1:0]     ram_wdata, ram_rdata;

  assign wr_in_range = (IPART_W'(in_data.row) < MAXH_I) && (IPART_W'(in_data.col) < MAXW_I);
  assign wr_addr     = AW'(in_data.row[RB-1:0]) * MAXW_A + AW'(in_data.col[CB-1:0]);
  assign rd_row      = cmd.rd_sel[1] ? r1_r : r0_r;
  assign rd_col      = cmd.rd_sel[0] ? c1_r : c0_r;
  assign rd_addr     = AW'(rd_row) * MAXW_A + AW'(rd_col);
  assign ram_addr    = cmd.rd_en ? rd_addr : wr_addr;
  assign ram_we      = cmd.wr_en && wr_in_range;
  assign ram_wdata   = {in_data.red_in, in_data.green_in, in_data.blue_in};

  bis_ram #(
    .WIDTH(PIX_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // weight of the neighbour being read, used when its data returns
  logic [FRAC_BITS:0] gr, gc, fr_x, fc_x, wa, wb;
  logic [WW-1:0]      wprod, w_r;

  assign fr_x = {1'b0, fr_r};
  assign fc_x = {1'b0, fc_r};
  assign gr   = ONE_F - fr_x;
  assign gc   = ONE_F - fc_x;

  always_comb begin
    case (cmd.rd_sel)
      2'd0: begin
        wa = gr;
        wb = gc;
      end
      2'd1: begin
        wa = gr;
        wb = fc_x;
      end
      2'd2: begin
        wa = fr_x;
        wb = gc;
      end
      2'd3: begin
        wa = fr_x;
        wb = fc_x;
      end
      default: begin
        wa = gr;
        wb = gc;
      end
    endcase
  end

  assign wprod = wa * wb;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      w_r <= wprod;
    end
  end

  // per-channel multiply-accumulate
  logic [ACC_W-1:0] term_red, term_green, term_blue;
  logic [ACC_W-1:0] acc_red_r, acc_green_r, acc_blue_r;

  assign term_red   = w_r * ram_rdata[23:16];
  assign term_green = w_r * ram_rdata[15:8];
  assign term_blue  = w_r * ram_rdata[7:0];

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc_red_r   <= '0;
      acc_green_r <= '0;
      acc_blue_r  <= '0;
    end else if (cmd.acc_en) begin
      acc_red_r   <= acc_red_r + term_red;
      acc_green_r <= acc_green_r + term_green;
      acc_blue_r  <= acc_blue_r + term_blue;
    end
  end

  // result register
  out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.red_out   <= acc_red_r[2*FRAC_BITS +: CHAN_W];
      out_data_r.green_out <= acc_green_r[2*FRAC_BITS +: CHAN_W];
      out_data_r.blue_out  <= acc_blue_r[2*FRAC_BITS +: CHAN_W];
    end
  end

  assign out_data = out_data_r;

endmodule

FILE: hdl/bilinear_image_scaler.sv
// ---------------------------------------------------------------------------
// bilinear_image_scaler
// Bilinear resize of an RGB source image held in an on-chip frame store.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  in_item_t: func, row, col, rgb
//   out_     output     out_valid/out_stall out_item_t: interpolated rgb
//   cfg_     input      cfg_we             cfg_index, cfg_data
//
// a pixel write leaves the stall low, so the next item is taken straight after
// a query passes from acceptance through a map state, four frame store
// reads through the single RAM port, an accumulate state that finishes the
// blend and a done state that loads the result register, then back to idle
// the result register lets a new item in while a result waits on out_stall
// synchronous active-low reset clears control state and the configuration
// registers; the frame store holds nothing until written
// ---------------------------------------------------------------------------
module bilinear_image_scaler #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bis_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bis_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bis_pkg::out_item_t             out_data
);
  import bis_pkg::*;

  dp_cmd_t cmd;

  bis_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd)
  );

  bis_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .out_data (out_data)
  );

endmodule

FILE: hdl/bis_checker.sv
// ---------------------------------------------------------------------------
// bis_checker
// Port-level checks of the scaler handshakes, bound to the top level.
// ---------------------------------------------------------------------------
module bis_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input bis_pkg::in_item_t              in_data,
  input logic                           out_valid,
  input logic                           out_stall,
  input bis_pkg::out_item_t             out_data
);
  import bis_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // a held result stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a query keeps the input stalled through the map and first read states
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.func == FUNC_QUERY |=> in_stall ##1 in_stall)
    else $error("item taken during a query");

  // a pixel write never blocks the next item
  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.func == FUNC_WRITE |=> !in_stall)
    else $error("stall after a pixel write");

  // a new result only appears at the end of a query sequence
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a query in flight");

endmodule

bind bilinear_image_scaler bis_checker u_bis_checker (.*);
